### rtl/core/ptrs_pkg.sv
// Shared types and constants for the periodic task release scheduler.
`timescale 1ns / 1ps

package ptrs_pkg;

  localparam int NUM_TASKS    = 8;
  localparam int PENDING_BITS = 8;
  localparam int IDX_W        = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int SLOT_W       = 4;
  localparam int PERIOD_W     = 16;
  localparam int TICK_W       = 32;
  localparam int ACTION_W     = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK     = 3'd0,
    ACT_DISPATCH = 3'd1,
    ACT_ADD      = 3'd2,
    ACT_ENABLE   = 3'd3,
    ACT_PERIOD   = 3'd4,
    ACT_RELEASE  = 3'd5,
    ACT_CLEAR    = 3'd6,
    ACT_UNUSED   = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_SWEEP,
    ST_MODIFY,
    ST_FINISH
  } state_t;

  // One task slot as held in the table.
  typedef struct packed {
    logic                    present;
    logic                    enabled;
    logic [PERIOD_W-1:0]     period;
    logic [PERIOD_W-1:0]     countdown;
    logic [PENDING_BITS-1:0] pending;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period;
    logic                enable_flag;
    logic                extra_release;
  } item_t;

  typedef struct packed {
    logic                ok;
    logic                dispatch_found;
    logic [SLOT_W-1:0]   dispatch_slot;
    logic [TICK_W-1:0]   tick_count;
  } result_t;

endpackage

### rtl/core/ptrs_table.sv
// Task slot table: one synchronous memory, registered read, per-entry valid bits.
`timescale 1ns / 1ps

module ptrs_table (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_en,
  input  logic [ptrs_pkg::IDX_W-1:0] rd_addr,
  output ptrs_pkg::entry_t        rd_data,
  input  logic                    wr_en,
  input  logic [ptrs_pkg::IDX_W-1:0] wr_addr,
  input  ptrs_pkg::entry_t        wr_data
);

  ptrs_pkg::entry_t                 mem [ptrs_pkg::NUM_TASKS];
  logic [ptrs_pkg::NUM_TASKS-1:0]   valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // An entry never written reads as the all-zero reset value.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

endmodule

### rtl/core/ptrs_ctrl.sv
// Sequencer: read-modify-write of the slot table for every action but a bad slot or the unused code.
`timescale 1ns / 1ps

module ptrs_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ptrs_pkg::item_t             in_item,
  output logic                        res_valid,
  input  logic                        res_ready,
  output ptrs_pkg::result_t           res,
  output logic                        rd_en,
  output logic [ptrs_pkg::IDX_W-1:0]  rd_addr,
  input  ptrs_pkg::entry_t            rd_data,
  output logic                        wr_en,
  output logic [ptrs_pkg::IDX_W-1:0]  wr_addr,
  output ptrs_pkg::entry_t            wr_data
);

  ptrs_pkg::state_t                    state;
  ptrs_pkg::state_t                    state_next;
  ptrs_pkg::action_t                   act;
  ptrs_pkg::action_t                   in_act;
  logic [ptrs_pkg::PERIOD_W-1:0]       period;
  logic                                enable_flag;
  logic                                extra_release;
  logic [ptrs_pkg::IDX_W-1:0]          idx;
  logic [ptrs_pkg::IDX_W-1:0]          proc_idx;
  logic [ptrs_pkg::TICK_W-1:0]         tick_counter;
  logic                                ok;
  logic                                found;
  logic [ptrs_pkg::IDX_W-1:0]          chosen;
  logic                                in_slot_ok;
  logic                                in_sweep;
  logic                                is_sweep;
  logic                                last;
  logic                                hit;
  logic                                mod_ok;
  ptrs_pkg::entry_t                    mod;

  function automatic logic [ptrs_pkg::PENDING_BITS-1:0] sat_inc(
    input logic [ptrs_pkg::PENDING_BITS-1:0] v
  );
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

  assign in_act     = ptrs_pkg::action_t'(in_item.action);
  assign in_slot_ok = {1'b0, in_item.slot} < (ptrs_pkg::SLOT_W + 1)'(ptrs_pkg::NUM_TASKS);
  assign in_sweep   = (in_act == ptrs_pkg::ACT_TICK) || (in_act == ptrs_pkg::ACT_DISPATCH);
  assign is_sweep   = (act == ptrs_pkg::ACT_TICK) || (act == ptrs_pkg::ACT_DISPATCH);
  assign last       = proc_idx == ptrs_pkg::IDX_W'(ptrs_pkg::NUM_TASKS - 1);

  // Modified copy of the entry that just came out of the table.
  always_comb begin
    mod    = rd_data;
    hit    = 1'b0;
    mod_ok = 1'b1;
    case (act)
      ptrs_pkg::ACT_TICK: begin
        if (rd_data.present && rd_data.enabled && rd_data.countdown != '0) begin
          mod.countdown = rd_data.countdown - 1'b1;
          if (mod.countdown == '0) begin
            mod.pending   = sat_inc(rd_data.pending);
            mod.countdown = rd_data.period;
          end
        end
      end
      ptrs_pkg::ACT_DISPATCH: begin
        if (rd_data.present && rd_data.enabled && rd_data.pending != '0) begin
          hit         = 1'b1;
          mod.pending = rd_data.pending - 1'b1;
        end
      end
      ptrs_pkg::ACT_ADD: begin
        mod.present   = 1'b1;
        mod.enabled   = 1'b1;
        mod.period    = period;
        mod.countdown = period;
        mod.pending   = ptrs_pkg::PENDING_BITS'(1);
      end
      ptrs_pkg::ACT_ENABLE: begin
        mod.enabled = enable_flag;
      end
      ptrs_pkg::ACT_PERIOD: begin
        mod.period    = period;
        mod.countdown = period;
        if (extra_release) begin
          mod.pending = sat_inc(rd_data.pending);
        end
      end
      ptrs_pkg::ACT_RELEASE: begin
        if (rd_data.present) begin
          mod.pending = sat_inc(rd_data.pending);
        end else begin
          mod_ok = 1'b0;
        end
      end
      ptrs_pkg::ACT_CLEAR: begin
        mod.pending = '0;
      end
      default: begin
        mod_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ptrs_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_sweep || (in_slot_ok && in_act != ptrs_pkg::ACT_UNUSED)) begin
            state_next = ptrs_pkg::ST_ISSUE;
          end else begin
            state_next = ptrs_pkg::ST_FINISH;
          end
        end
      end
      ptrs_pkg::ST_ISSUE: begin
        state_next = is_sweep ? ptrs_pkg::ST_SWEEP : ptrs_pkg::ST_MODIFY;
      end
      ptrs_pkg::ST_SWEEP: begin
        if (last || (act == ptrs_pkg::ACT_DISPATCH && hit)) begin
          state_next = ptrs_pkg::ST_FINISH;
        end
      end
      ptrs_pkg::ST_MODIFY: begin
        state_next = ptrs_pkg::ST_FINISH;
      end
      ptrs_pkg::ST_FINISH: begin
        if (res_ready) begin
          state_next = ptrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ptrs_pkg::ST_IDLE;
      end
    endcase
  end

  // Sweep reads slot proc_idx+1 while writing slot proc_idx, so the
  // two ports never touch the same entry in one cycle.
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    unique case (state)
      ptrs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      ptrs_pkg::ST_ISSUE: begin
        rd_en = 1'b1;
      end
      ptrs_pkg::ST_SWEEP: begin
        rd_en = !last && !(act == ptrs_pkg::ACT_DISPATCH && hit);
        wr_en = (act == ptrs_pkg::ACT_TICK) || hit;
      end
      ptrs_pkg::ST_MODIFY: begin
        wr_en = 1'b1;
      end
      ptrs_pkg::ST_FINISH: begin
        res_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign rd_addr = idx;
  assign wr_addr = proc_idx;
  assign wr_data = mod;

  assign res.ok             = ok;
  assign res.dispatch_found = found;
  assign res.dispatch_slot  = ptrs_pkg::SLOT_W'(chosen);
  assign res.tick_count     = tick_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ptrs_pkg::ST_IDLE;
      tick_counter <= '0;
    end else begin
      state <= state_next;
      if (state == ptrs_pkg::ST_IDLE && in_valid && in_act == ptrs_pkg::ACT_TICK) begin
        tick_counter <= tick_counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ptrs_pkg::ST_IDLE: begin
        if (in_valid) begin
          act           <= in_act;
          period        <= in_item.period;
          enable_flag   <= in_item.enable_flag;
          extra_release <= in_item.extra_release;
          idx           <= in_sweep ? '0 : in_item.slot[ptrs_pkg::IDX_W-1:0];
          ok            <= in_act == ptrs_pkg::ACT_TICK;
          found         <= 1'b0;
          chosen        <= '0;
        end
      end
      ptrs_pkg::ST_ISSUE: begin
        proc_idx <= idx;
        idx      <= idx + 1'b1;
      end
      ptrs_pkg::ST_SWEEP: begin
        if (act == ptrs_pkg::ACT_DISPATCH && hit) begin
          ok     <= 1'b1;
          found  <= 1'b1;
          chosen <= proc_idx;
        end else if (!last) begin
          proc_idx <= idx;
          idx      <= idx + 1'b1;
        end
      end
      ptrs_pkg::ST_MODIFY: begin
        ok <= mod_ok;
      end
      default: begin
        ok <= ok;
      end
    endcase
  end

endmodule

### rtl/core/periodic_task_release_scheduler_top.sv
// Top level of the periodic task release scheduler: stream ports and result register.
//
//   Port group   Dir   Payload
//   s_axis_*     in    tuser = action; tdata = slot, period, enable_flag, extra_release
//   m_axis_*     out   tdata = ok, dispatch_found, dispatch_slot, tick_count
//
// Tick sweeps every slot: one table read-modify-write per slot, pipelined.
// Dispatch sweeps from slot 0 and stops at the first slot with a pending release, or after the last.
// Slot actions read-modify-write one entry; a bad slot or unused action code skips the table.
// The result register frees the sequencer, so a new item is taken while a result waits.
// Synchronous reset empties the table (valid bits) and zeroes the tick counter at once.
`timescale 1ns / 1ps

module periodic_task_release_scheduler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [3:0] slot, [19:4] period, [20] enable_flag,
                                     // [21] extra_release, [23:22] zero
  input  logic [2:0]  s_axis_tuser,  // [2:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [0] ok, [1] dispatch_found, [5:2] dispatch_slot,
                                     // [37:6] tick_count, [39:38] zero
);

  ptrs_pkg::item_t                   item;
  ptrs_pkg::result_t                 res;
  ptrs_pkg::result_t                 out_res;
  logic                              res_valid;
  logic                              res_ready;
  logic                              rd_en;
  logic [ptrs_pkg::IDX_W-1:0]        rd_addr;
  ptrs_pkg::entry_t                  rd_data;
  logic                              wr_en;
  logic [ptrs_pkg::IDX_W-1:0]        wr_addr;
  ptrs_pkg::entry_t                  wr_data;

  assign item.action        = s_axis_tuser;
  assign item.slot          = s_axis_tdata[3:0];
  assign item.period        = s_axis_tdata[19:4];
  assign item.enable_flag   = s_axis_tdata[20];
  assign item.extra_release = s_axis_tdata[21];

  ptrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  ptrs_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {2'b00, out_res.tick_count, out_res.dispatch_slot,
                         out_res.dispatch_found, out_res.ok};

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && res_valid))
    else $error("input ready while a result is pending");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.dispatch_found |-> res.ok)
    else $error("dispatch found a slot but ok is low");

  a_none_slot_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.dispatch_found |-> res.dispatch_slot == '0)
    else $error("dispatch slot nonzero without a find");

  a_tick_count: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ptrs_pkg::ACT_TICK
    |=> res.tick_count == $past(res.tick_count) + 32'd1)
    else $error("tick counter did not advance on a tick");

endmodule
